@@ sv/assert_macros.svh @@
// Assertion macros shared by the header builder RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent on the same edge.
`define ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Check that an antecedent implies a consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

@@ sv/srv6_pkg.sv @@
// Types and constants for the SRv6 encapsulation header builder.
// No dependencies.
package srv6_pkg;
   localparam logic [1:0] OP_PKT = 2'd0;
   localparam logic [1:0] OP_PREFIX = 2'd1;
   localparam logic [1:0] OP_SEG = 2'd2;
   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [15:0] ETH_IPV6 = 16'h86DD;
   localparam logic [7:0] LINK_LOCAL_BYTE = 8'hfe;
   localparam logic [7:0] NH_ROUTING = 8'd43;
   localparam logic [7:0] NH_IPV6 = 8'd41;
   localparam logic [7:0] SRH_TYPE = 8'd4;
   localparam logic [7:0] ADDR_BITS = 8'd128;

   typedef struct packed {
      logic [1:0] opcode;
      logic [3:0] entry_index;
      logic [2:0] seg_index;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0] prefix_len;
      logic [3:0] num_segs;
      logic [3:0] seg_left;
      logic [63:0] hdr_word0;
      logic [7:0] dst_top_byte;
      logic [15:0] ethertype;
   } req_type;

   typedef struct packed {
      logic action;
      logic [63:0] header_word;
      logic last;
   } rsp_type;

   // Prefix table entry as stored in memory
   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0] prefix_length;
      logic [3:0] segment_count;
      logic [3:0] active_segment;
   } entry_type;

   // Top bits mask of a 64-bit half
   function automatic logic [63:0] mask_top(input logic [7:0] bits);
      logic [63:0] m;
      if (bits == 8'd0) m = '0;
      else if (bits >= 8'd64) m = '1;
      else m = ~64'd0 << (7'd64 - bits[6:0]);
      return m;
   endfunction
endpackage

@@ sv/srv6_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module srv6_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

@@ sv/srv6_encap_header_builder.sv @@
// Top level of the SRv6 encapsulation header builder.
// Depends on srv6_pkg, srv6_ram and assert_macros.svh.
// A request is taken when start is high and busy is low. A table write keeps
// busy high for one cycle, in ST_WAIT, before the next request can be taken.
// A packet walks the prefix table one entry per cycle through the entry
// memory's read port until an entry matches or the last entry misses. A match
// then emits 6+2n header words, one per cycle, with the segment words read from
// the segment memory; a packet that passes emits a single pass result. Each
// result shows on rsp_valid in the cycle after it is formed, for one cycle, and
// the receiver cannot stall it. Busy stays high from the request until the
// last header word or the pass result is formed. No clearing pass: entry valid
// bits reset at once.
`include "assert_macros.svh"
module srv6_encap_header_builder #(
   parameter int TABLE_ENTRIES = 16,
   parameter int MAX_SEGMENTS = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  srv6_pkg::req_type req_data,
   output logic rsp_valid,
   output srv6_pkg::rsp_type rsp_data
);
   import srv6_pkg::*;

   localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int SEG_DEPTH = TABLE_ENTRIES * MAX_SEGMENTS;
   localparam int AW = $clog2(SEG_DEPTH) > 0 ? $clog2(SEG_DEPTH) : 1;
   localparam int EDEPTH = TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2;
   localparam int SDEPTH = SEG_DEPTH > 1 ? SEG_DEPTH : 2;
   localparam int ECW = EW + 1;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_EMIT = 5'b00100,
      ST_WAIT = 5'b01000,
      ST_PASS = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [ECW-1:0] scan_ff, scan_in;   // one past the entry under compare
   logic [EW-1:0] sel_ff, sel_in;
   logic [3:0] n_ff, n_in, act_ff, act_in;
   logic [5:0] word_ff, word_in;
   logic [4:0] segi_ff, segi_in;

   // Entry memory
   entry_type e_wdata, e_rdata;
   logic e_we;
   logic [EW-1:0] e_waddr, e_raddr;
   assign e_we = start && !busy && req_data.opcode == OP_PREFIX &&
                 32'(req_data.entry_index) < TABLE_ENTRIES;
   assign e_waddr = EW'(req_data.entry_index);
   assign e_wdata = '{addr_hi: req_data.addr_hi, addr_lo: req_data.addr_lo,
                      prefix_length: req_data.prefix_len,
                      segment_count: req_data.num_segs,
                      active_segment: req_data.seg_left};
   assign e_raddr = EW'(scan_in - 1'b1);

   srv6_ram #(.WIDTH($bits(entry_type)), .DEPTH(EDEPTH)) u_entry_ram (
      .clock(clock), .wr_en(e_we), .wr_addr(e_waddr), .wr_data(e_wdata),
      .rd_addr(e_raddr), .rd_data(e_rdata));

   // Segment memory
   logic s_we;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [63:0] s_hi, s_lo;
   assign s_we = start && !busy && req_data.opcode == OP_SEG &&
                 32'(req_data.entry_index) < TABLE_ENTRIES &&
                 32'(req_data.seg_index) < MAX_SEGMENTS;
   assign s_waddr = AW'(32'(req_data.entry_index) * MAX_SEGMENTS +
                        32'(req_data.seg_index));

   srv6_ram #(.WIDTH(64), .DEPTH(SDEPTH)) u_seg_hi_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(req_data.addr_hi),
      .rd_addr(s_raddr), .rd_data(s_hi));
   srv6_ram #(.WIDTH(64), .DEPTH(SDEPTH)) u_seg_lo_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(req_data.addr_lo),
      .rd_addr(s_raddr), .rd_data(s_lo));

   // Prefix compare of the entry read last cycle
   logic [7:0] plen, plen_lo;
   logic hit, bad;
   logic [EW-1:0] cur;
   assign cur = EW'(scan_ff - 1'b1);
   always_comb begin
      plen = (e_rdata.prefix_length > ADDR_BITS) ? ADDR_BITS : e_rdata.prefix_length;
      plen_lo = (plen > 8'd64) ? plen - 8'd64 : 8'd0;
      hit = valid_ff[cur] &&
            (((req_ff.addr_hi ^ e_rdata.addr_hi) & mask_top(plen)) == '0) &&
            (((req_ff.addr_lo ^ e_rdata.addr_lo) & mask_top(plen_lo)) == '0);
      bad = ({1'b0, e_rdata.segment_count} > 5'(MAX_SEGMENTS)) ||
            (e_rdata.active_segment >= e_rdata.segment_count);
   end

   // Segment read address: active segment for words 3,4, list otherwise
   logic [4:0] seg_pick;
   assign seg_pick = (word_in == 6'd3 || word_in == 6'd4) ? {1'b0, act_in} : segi_in;
   assign s_raddr = AW'(32'(sel_in) * MAX_SEGMENTS + 32'(seg_pick));

   // Control
   logic [5:0] total;
   logic [15:0] plen16;
   logic [7:0] hop, dec;
   rsp_type rsp_in;
   logic rsp_valid_in;
   assign total = 6'd6 + {1'b0, n_ff, 1'b0};

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      valid_in = valid_ff;
      scan_in = scan_ff;
      sel_in = sel_ff;
      n_in = n_ff;
      act_in = act_ff;
      word_in = word_ff;
      segi_in = segi_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '0;
      plen16 = req_ff.hdr_word0[31:16] + 16'd48 + {8'd0, n_ff, 4'd0};
      dec = {4'd0, n_ff} - {4'd0, act_ff};
      hop = (req_ff.hdr_word0[7:0] > dec) ? req_ff.hdr_word0[7:0] - dec : 8'd0;
      case (state_ff)
         ST_IDLE: begin
            scan_in = '0;
            if (e_we) valid_in[e_waddr] = 1'b1;
            if (start && req_data.opcode == OP_PKT) begin
               req_in = req_data;
               if (req_data.ethertype == ETH_IPV6 &&
                   req_data.dst_top_byte != LINK_LOCAL_BYTE) begin
                  scan_in = ECW'(1);
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_PASS;
               end
            end else if (start) begin
               state_in = ST_WAIT;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               if (bad) state_in = ST_PASS;
               else begin
                  sel_in = cur;
                  n_in = e_rdata.segment_count;
                  act_in = e_rdata.active_segment;
                  word_in = '0;
                  segi_in = '0;
                  state_in = ST_EMIT;
               end
            end else if (scan_ff == ECW'(TABLE_ENTRIES)) begin
               state_in = ST_PASS;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.action = 1'b1;
            rsp_in.last = (word_ff == total - 6'd1);
            case (word_ff)
               6'd0: rsp_in.header_word = {req_ff.hdr_word0[63:32], plen16,
                                           NH_ROUTING, hop};
               6'd1: rsp_in.header_word = req_ff.addr_hi;
               6'd2: rsp_in.header_word = req_ff.addr_lo;
               6'd3: rsp_in.header_word = s_hi;
               6'd4: rsp_in.header_word = s_lo;
               6'd5: rsp_in.header_word = {NH_IPV6, 3'd0, n_ff, 1'b0, SRH_TYPE,
                                           4'd0, act_ff, 4'd0, 4'(n_ff - 4'd1),
                                           24'd0};
               default: rsp_in.header_word = word_ff[0] ? s_lo : s_hi;
            endcase
            word_in = word_ff + 6'd1;
            if (word_ff >= 6'd6 && word_ff[0]) segi_in = segi_ff + 5'd1;
            if (rsp_in.last) state_in = ST_IDLE;
         end
         ST_PASS: begin
            rsp_valid_in = 1'b1;
            rsp_in.last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_WAIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   rsp_type rsp_ff;
   logic rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff <= '0;
         word_ff <= '0;
         segi_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff <= scan_in;
         word_ff <= word_in;
         segi_ff <= segi_in;
      end
      req_ff <= req_in;
      sel_ff <= sel_in;
      n_ff <= n_in;
      act_ff <= act_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy, "request not held off")
   `ASSERT_IMP(a_pass_last, clock, reset, rsp_valid && !rsp_data.action,
               rsp_data.last && rsp_data.header_word == '0, "bad pass result")
   `ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !rsp_valid,
                "result after last")
endmodule

@@ tb/sv/srv6_encap_checker.sv @@
// Checker for the SRv6 encapsulation header builder: predicts header words.
// Depends on srv6_pkg; watches the request and result channels of the top.
`timescale 1ns / 100ps
module srv6_encap_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  srv6_pkg::req_type req_data,
   input  logic rsp_valid,
   input  srv6_pkg::rsp_type rsp_data,
   output int fail_count,
   output int pending_words
);
   import srv6_pkg::*;
   localparam int ENTRIES = 16;
   localparam int SEGS = 8;

   logic valid_q [ENTRIES];
   entry_type entry_q [ENTRIES];
   logic [63:0] seg_hi_q [ENTRIES*SEGS];
   logic [63:0] seg_lo_q [ENTRIES*SEGS];
   rsp_type header_queue [$];

   // Top-bit mask of one address half
   function automatic logic [63:0] top_mask(input int bits);
      if (bits <= 0) return '0;
      if (bits >= 64) return '1;
      return ~64'd0 << (64 - bits);
   endfunction

   function automatic rsp_type make_word(input logic [63:0] w, input logic l);
      rsp_type r;
      r.action = 1'b1;
      r.header_word = w;
      r.last = l;
      return r;
   endfunction

   // Update the table copies for a write, or build the expected header words for a packet
   task automatic predict_request(input req_type q);
      int e, len, n, act, hop, dec, found, base;
      logic [15:0] plen;
      rsp_type r;
      found = 0;
      e = 0;
      if (q.opcode == OP_PREFIX) begin
         valid_q[q.entry_index] = 1'b1;
         entry_q[q.entry_index] = {q.addr_hi, q.addr_lo, q.prefix_len, q.num_segs, q.seg_left};
         return;
      end
      if (q.opcode == OP_SEG) begin
         seg_hi_q[q.entry_index*SEGS + q.seg_index] = q.addr_hi;
         seg_lo_q[q.entry_index*SEGS + q.seg_index] = q.addr_lo;
         return;
      end
      if (q.opcode != OP_PKT) return;
      if (q.ethertype == ETH_IPV6 && q.dst_top_byte != LINK_LOCAL_BYTE) begin
         for (e = 0; e < ENTRIES; e++) begin
            if (valid_q[e]) begin
               len = entry_q[e].prefix_length;
               if (len > 128) len = 128;
               if (((q.addr_hi ^ entry_q[e].addr_hi) & top_mask(len)) == 0 &&
                   ((q.addr_lo ^ entry_q[e].addr_lo) & top_mask(len - 64)) == 0) begin
                  found = 1;
                  break;
               end
            end
         end
      end
      if (found) begin
         n = entry_q[e].segment_count;
         act = entry_q[e].active_segment;
         if (n > SEGS || act >= n) found = 0;
      end
      if (!found) begin
         r = '0;
         r.last = 1'b1;
         header_queue.push_back(r);
         return;
      end
      base = e * SEGS;
      plen = q.hdr_word0[31:16] + 16'(48 + 16 * n);
      hop = q.hdr_word0[7:0];
      dec = n - act;
      hop = (hop > dec) ? hop - dec : 0;
      header_queue.push_back(make_word({q.hdr_word0[63:32], plen, NH_ROUTING, 8'(hop)}, 1'b0));
      header_queue.push_back(make_word(q.addr_hi, 1'b0));
      header_queue.push_back(make_word(q.addr_lo, 1'b0));
      header_queue.push_back(make_word(seg_hi_q[base + act], 1'b0));
      header_queue.push_back(make_word(seg_lo_q[base + act], 1'b0));
      header_queue.push_back(make_word({NH_IPV6, 8'(2 * n), SRH_TYPE, 8'(act),
                                        8'(n - 1), 24'd0}, 1'b0));
      for (int i = 0; i < n; i++) begin
         header_queue.push_back(make_word(seg_hi_q[base + i], 1'b0));
         header_queue.push_back(make_word(seg_lo_q[base + i], i + 1 == n));
      end
   endtask

   // Predict on each accepted request, compare each result with the oldest word
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) valid_q[i] = 1'b0;
         fail_count = 0;
         pending_words = 0;
      end else begin
         if (rsp_valid) begin
            if (header_queue.size() == 0) begin
               $error("unexpected result word %h", rsp_data.header_word);
               fail_count++;
            end else begin
               want = header_queue.pop_front();
               if (want.action !== rsp_data.action) begin
                  $error("action expected %0d actual %0d", want.action, rsp_data.action);
                  fail_count++;
               end
               if (want.header_word !== rsp_data.header_word) begin
                  $error("header_word expected %h actual %h", want.header_word,
                         rsp_data.header_word);
                  fail_count++;
               end
               if (want.last !== rsp_data.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_data.last);
                  fail_count++;
               end
            end
         end
         if (start && !busy) predict_request(req_data);
         pending_words = header_queue.size();
      end
   end
endmodule

@@ tb/sv/tb_srv6_encap_header_builder.sv @@
// Testbench top for the SRv6 encapsulation header builder.
// Depends on srv6_pkg, srv6_encap_header_builder and srv6_encap_checker.
`timescale 1ns / 100ps
module tb_srv6_encap_header_builder;
   import srv6_pkg::*;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   int fail_count;
   int pending_words;
   int cycle_count = 0;
   int idle_pct;
   logic [63:0] prefix_hi [16];
   logic [63:0] prefix_lo [16];
   logic [7:0] prefix_bits [16];
   logic seg_written [16][8];

   srv6_encap_header_builder u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   srv6_encap_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_words(pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_type random_fields();
      logic [287:0] bits;
      req_type q;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
      q = bits[$bits(req_type)-1:0];
      return q;
   endfunction

   // True once a prefix has been written to entry e
   function automatic logic u_checker_ready(input int e);
      return prefix_bits[e] !== 8'bx;
   endfunction

   // Issue one request and hold it until accepted; start stays up on return
   task automatic send_request(input req_type q);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop start and wait until every expected result has come
   task automatic drain();
      start <= 1'b0;
      wait (pending_words == 0);
      @(negedge clock);
   endtask

   // Load a prefix entry; keep segment writes ahead of use
   task automatic write_prefix(input int e, input logic [63:0] hi, input logic [63:0] lo,
                               input int bits, input int n, input int act);
      req_type q;
      q = random_fields();
      q.opcode = OP_PREFIX;
      q.entry_index = 4'(e);
      q.addr_hi = hi;
      q.addr_lo = lo;
      q.prefix_len = 8'(bits);
      q.num_segs = 4'(n);
      q.seg_left = 4'(act);
      prefix_hi[e] = hi;
      prefix_lo[e] = lo;
      prefix_bits[e] = 8'(bits);
      send_request(q);
   endtask

   task automatic write_segment(input int e, input int s);
      req_type q;
      q = random_fields();
      q.opcode = OP_SEG;
      q.entry_index = 4'(e);
      q.seg_index = 3'(s);
      seg_written[e][s] = 1'b1;
      send_request(q);
   endtask

   task automatic send_packet(input logic [63:0] hi, input logic [63:0] lo,
                              input logic [63:0] w0, input int etype, input int dtop);
      req_type q;
      q = random_fields();
      q.opcode = OP_PKT;
      q.addr_hi = hi;
      q.addr_lo = lo;
      q.hdr_word0 = w0;
      q.ethertype = 16'(etype);
      q.dst_top_byte = 8'(dtop);
      send_request(q);
   endtask

   // Source near entry e's prefix, sometimes flipping a low bit to miss
   task automatic packet_near(input int e);
      logic [63:0] hi, lo;
      int b;
      hi = rand64();
      lo = rand64();
      hi = (prefix_hi[e] & ~(~64'd0 >> (prefix_bits[e] > 63 ? 64 : prefix_bits[e]))) |
           (hi & (~64'd0 >> (prefix_bits[e] > 63 ? 64 : prefix_bits[e])));
      if (prefix_bits[e] > 64) begin
         b = prefix_bits[e] > 128 ? 64 : prefix_bits[e] - 64;
         lo = (prefix_lo[e] & ~(~64'd0 >> b)) | (lo & (~64'd0 >> b));
      end
      if ($urandom_range(9) == 0) lo[$urandom_range(63)] ^= 1'b1;
      send_packet(hi, lo, rand64(), $urandom_range(19) == 0 ? $urandom_range(65535) : ETH_IPV6,
                  $urandom_range(19) == 0 ? LINK_LOCAL_BYTE : $urandom_range(255));
   endtask

   initial begin
      int e, n, act, kind;
      req_type q;
      idle_pct = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      for (int i = 0; i < 16; i++) for (int s = 0; s < 8; s++) seg_written[i][s] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, non-IPv6, link-local, opcode 3
      send_packet(rand64(), rand64(), rand64(), ETH_IPV6, 8'h20);
      q = random_fields();
      q.opcode = OP_IGNORED;
      send_request(q);
      for (int s = 0; s < 8; s++) write_segment(0, s);
      write_prefix(0, '1, '1, 128, 8, 7);
      send_packet('1, '1, 64'hFFFF_FFFF_FFFF_FF01, ETH_IPV6, 8'h00);
      send_packet('1, '1, 64'h0, 16'h0800, 8'h20);
      send_packet('1, '1, 64'h0, ETH_IPV6, LINK_LOCAL_BYTE);
      // Long prefix, zero prefix, bad counts, hop saturation, length wrap
      write_prefix(0, '0, '0, 255, 8, 0);
      send_packet('0, '0, 64'h0000_0000_FFF0_0003, ETH_IPV6, 8'hff);
      write_prefix(1, rand64(), rand64(), 0, 9, 0);
      send_packet('1, '0, rand64(), ETH_IPV6, 8'h20);
      write_prefix(1, rand64(), rand64(), 0, 0, 0);
      send_packet('1, '0, rand64(), ETH_IPV6, 8'h20);
      write_prefix(1, rand64(), rand64(), 0, 4, 4);
      send_packet('1, '0, rand64(), ETH_IPV6, 8'h20);
      write_segment(1, 0);
      write_prefix(1, rand64(), rand64(), 0, 1, 0);
      send_packet(rand64(), rand64(), rand64(), ETH_IPV6, 8'h20);
      drain();

      // Random: mostly table writes and matching packets over idling phases
      for (int item = 0; item < 400; item++) begin
         if (item % 100 == 0) begin
            idle_pct = (item / 100 == 1) ? 77 : ((item / 100 == 3) ? 23 : 0);
         end
         if (item == 200) drain();
         kind = $urandom_range(9);
         e = $urandom_range(15);
         if (kind < 2) begin
            n = $urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(1, 8);
            act = $urandom_range(9) == 0 ? $urandom_range(15) : $urandom_range(n > 0 ? n - 1 : 0);
            for (int s = 0; s < 8; s++) if (!seg_written[e][s]) write_segment(e, s);
            kind = $urandom_range(3);
            write_prefix(e, rand64(), rand64(),
                         kind == 0 ? $urandom_range(255) : $urandom_range(128), n, act);
         end else if (kind < 4) begin
            q = random_fields();
            if (q.opcode == OP_PKT || q.opcode == OP_PREFIX) q.opcode = OP_SEG;
            if (q.opcode == OP_SEG) seg_written[q.entry_index][q.seg_index] = 1'b1;
            send_request(q);
         end else if (kind < 9 && u_checker_ready(e)) begin
            packet_near(e);
         end else begin
            send_packet(rand64(), rand64(), rand64(), ETH_IPV6, $urandom_range(255));
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
